// ===== rtl/lbvs_pkg.sv =====
package lbvs_pkg;

	typedef enum logic [1:0] {
		REQ_SKIN   = 2'd0,
		REQ_MATRIX = 2'd1,
		REQ_REMAP  = 2'd2,
		REQ_NONE   = 2'd3
	} req_e;

	// weighted lane sum and cross-lane accumulator widths
	localparam int unsigned WSUM_W = 59;
	localparam int unsigned ACC_W  = 61;

	// matrix word write, issued when a load leaves stage 1
	typedef struct packed {
		logic        en;
		logic [3:0]  pos;
		logic [31:0] data;
	} lbvs_mwr_t;

	// remap entry write, issued on the transfer of a load
	typedef struct packed {
		logic       en;
		logic [7:0] addr;
		logic [7:0] data;
	} lbvs_rwr_t;

endpackage

// ===== rtl/linear_blend_vertex_skinning.sv =====
// Linear blend skinning, up to four bones per vertex. A skin transfer
// (req_type 0) gives one result; matrix and remap loads (req_type 1 and 2) give
// none, and req_type 3 is dropped. One item enters every cycle while the pipe
// is not held: each bone lane owns its own copy of the remap table and twelve
// simple dual-port matrix word memories (rows 0..2 and the translation row), so
// all lanes fetch a full matrix at once. The whole pipe advances as one and
// holds only while the output register is full and not taken. A matrix load is
// committed as it leaves stage 1, in order with the skin reads there, and a remap
// load as it transfers, in order with the remap reads; a vertex therefore sees
// every load transferred before it. Results are Q16.16, rounded to nearest after
// the 1/255 weighting and saturated to 32 bits. The user must write use_remap
// via the cfg channel only while the block is idle; the block does not check it.
module linear_blend_vertex_skinning
	import lbvs_pkg::*;
#(
	parameter int unsigned MATRIX_COUNT     = 256,
	parameter int unsigned BONES_PER_VERTEX = 4,
	parameter int unsigned REMAP_DEPTH      = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] nrm_x,
	input  logic signed [31:0] nrm_y,
	input  logic signed [31:0] nrm_z,
	input  logic [31:0]        bone_indices,
	input  logic [31:0]        bone_weights,
	input  logic [63:0]        uv_bits,
	input  logic [63:0]        table_write,
	input  logic               last_vertex,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] out_pos_x,
	output logic signed [31:0] out_pos_y,
	output logic signed [31:0] out_pos_z,
	output logic signed [31:0] out_nrm_x,
	output logic signed [31:0] out_nrm_y,
	output logic signed [31:0] out_nrm_z,
	output logic [63:0]        out_uv_bits,
	output logic               out_last
);

	localparam int unsigned NL  = (BONES_PER_VERTEX < 4) ? BONES_PER_VERTEX : 4;
	localparam int unsigned MIW = (MATRIX_COUNT > 1) ? $clog2(MATRIX_COUNT) : 1;
	localparam int unsigned NST = 10;

	typedef struct packed {
		logic [63:0] uv;
		logic        last;
	} side_t;

	logic use_remap_q;
	logic adv, acc;
	logic vld_s [1:NST];
	side_t side_s [1:NST];

	// one enable for the whole pipe: stall only on a held result
	assign adv       = !vld_s[NST] || out_ready;
	assign in_ready  = adv;
	assign acc       = in_valid && adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_remap_q <= 1'b0;
		end else if (cfg_valid) begin
			use_remap_q <= cfg_data;
		end
	end

	// stage 1 sees every transfer; from stage 2 on only skin items are valid
	logic [1:0]         req_s1;
	logic               mok_s1;
	logic [31:0]        maddr_s1, mdata_s1;
	logic signed [31:0] pos_s1 [3], nrm_s1 [3], pos_s2 [3], nrm_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 1; s <= NST; s++) begin
				vld_s[s] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[1] <= in_valid;
			vld_s[2] <= vld_s[1] && req_s1 == REQ_SKIN;
			for (int s = 3; s <= NST; s++) begin
				vld_s[s] <= vld_s[s-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1    <= req_type;
			mok_s1    <= table_write[63:32] < 32'(MATRIX_COUNT * 16);
			maddr_s1  <= table_write[63:32];
			mdata_s1  <= table_write[31:0];
			pos_s1    <= '{pos_x, pos_y, pos_z};
			nrm_s1    <= '{nrm_x, nrm_y, nrm_z};
			pos_s2    <= pos_s1;
			nrm_s2    <= nrm_s1;
			side_s[1] <= '{uv: uv_bits, last: last_vertex};
			for (int s = 2; s <= NST; s++) begin
				side_s[s] <= side_s[s-1];
			end
		end
	end

	lbvs_mwr_t mwr;
	lbvs_rwr_t rwr;

	assign mwr.en   = adv && vld_s[1] && req_s1 == REQ_MATRIX && mok_s1;
	assign mwr.pos  = maddr_s1[3:0];
	assign mwr.data = mdata_s1;

	assign rwr.en   = acc && req_type == REQ_REMAP
		&& table_write[63:32] < 32'(REMAP_DEPTH);
	assign rwr.addr = table_write[39:32];
	assign rwr.data = table_write[7:0];

	logic signed [WSUM_W-1:0] wsum_s5 [NL][6];

	for (genvar l = 0; l < NL; l++) begin : g_lane
		lbvs_lane #(
			.MATRIX_COUNT (MATRIX_COUNT),
			.REMAP_DEPTH  (REMAP_DEPTH),
			.MIW          (MIW)
		) u_lane (
			.clk       (clk),
			.adv       (adv),
			.use_remap (use_remap_q),
			.rwr       (rwr),
			.bone      (bone_indices[8*l +: 8]),
			.weight    (bone_weights[8*l +: 8]),
			.mwr       (mwr),
			.mwr_idx   (maddr_s1[MIW+3:4]),
			.pos_s2    (pos_s2),
			.nrm_s2    (nrm_s2),
			.wsum_s5   (wsum_s5[l])
		);
	end

	// sum the weighted lanes exactly, then divide by 255 and saturate
	logic signed [ACC_W-1:0] acc_s6 [6];
	logic signed [31:0]      res_s10 [6];

	always_ff @(posedge clk) begin
		logic signed [ACC_W-1:0] a;
		if (adv) begin
			for (int k = 0; k < 6; k++) begin
				a = '0;
				for (int l = 0; l < NL; l++) begin
					a = a + ACC_W'(wsum_s5[l][k]);
				end
				acc_s6[k] <= a;
			end
		end
	end

	for (genvar k = 0; k < 6; k++) begin : g_fin
		lbvs_div255 u_div (
			.clk     (clk),
			.adv     (adv),
			.acc     (acc_s6[k]),
			.res_s10 (res_s10[k])
		);
	end

	assign out_valid   = vld_s[NST];
	assign out_pos_x   = res_s10[0];
	assign out_pos_y   = res_s10[1];
	assign out_pos_z   = res_s10[2];
	assign out_nrm_x   = res_s10[3];
	assign out_nrm_y   = res_s10[4];
	assign out_nrm_z   = res_s10[5];
	assign out_uv_bits = side_s[NST].uv;
	assign out_last    = side_s[NST].last;

`ifndef SYNTH
	// loads and unused requests never reach the arithmetic stages
	a_load_drop: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_s[1] && req_s1 != REQ_SKIN |=> !vld_s[2])
		else $error("non-skin item entered stage 2");

	// a stall freezes the valid chain
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> vld_s[5] == $past(vld_s[5]) && vld_s[9] == $past(vld_s[9]))
		else $error("valid bit moved during stall");

	// matrix writes only come from a valid stage-1 load during advance
	a_mwr_src: assert property (@(posedge clk) disable iff (!arst_n)
		mwr.en |-> vld_s[1] && adv && req_s1 == REQ_MATRIX)
		else $error("stray matrix write");
`endif

endmodule

// ===== rtl/lbvs_lane.sv =====
module lbvs_lane
	import lbvs_pkg::*;
#(
	parameter int unsigned MATRIX_COUNT = 256,
	parameter int unsigned REMAP_DEPTH  = 256,
	parameter int unsigned MIW          = 8
) (
	input  logic                     clk,
	input  logic                     adv,
	input  logic                     use_remap,
	input  lbvs_rwr_t                rwr,
	input  logic [7:0]               bone,
	input  logic [7:0]               weight,
	input  lbvs_mwr_t                mwr,
	input  logic [MIW-1:0]           mwr_idx,
	input  logic signed [31:0]       pos_s2 [3],
	input  logic signed [31:0]       nrm_s2 [3],
	output logic signed [WSUM_W-1:0] wsum_s5 [6]
);

	localparam int unsigned RIW = (REMAP_DEPTH > 1) ? $clog2(REMAP_DEPTH) : 1;

	// index folding tables
	logic [RIW-1:0] rmod [256];
	logic [MIW-1:0] mmod [256];

	for (genvar k = 0; k < 256; k++) begin : g_mod
		assign rmod[k] = RIW'(k % REMAP_DEPTH);
		assign mmod[k] = MIW'(k % MATRIX_COUNT);
	end

	logic [7:0] rmem [REMAP_DEPTH];
	logic [7:0] b_s1, rm_s1, w_s1, w_s2, w_s3, w_s4;

	always_ff @(posedge clk) begin
		if (rwr.en) begin
			rmem[rwr.addr[RIW-1:0]] <= rwr.data;
		end
		if (adv) begin
			b_s1  <= bone;
			w_s1  <= weight;
			rm_s1 <= rmem[rmod[bone]];
		end
	end

	logic [7:0]     bsel;
	logic [MIW-1:0] midx;
	assign bsel = use_remap ? rm_s1 : b_s1;
	assign midx = mmod[bsel];

	// words 0..8 are rows 0..2 by column, 9..11 the translation row
	logic signed [31:0] m_s2 [12];

	for (genvar p = 0; p < 12; p++) begin : g_word
		localparam logic [3:0] WP = 4'((p / 3) * 4 + (p % 3));
		logic [31:0] mem [MATRIX_COUNT];
		always_ff @(posedge clk) begin
			if (mwr.en && mwr.pos == WP) begin
				mem[mwr_idx] <= mwr.data;
			end
			if (adv) begin
				m_s2[p] <= mem[midx];
			end
		end
	end

	logic signed [47:0] pp_s3 [2][3][3];
	logic signed [31:0] tr_s3 [3];
	logic signed [49:0] sum_s4 [2][3];

	for (genvar r = 0; r < 3; r++) begin : g_row
		for (genvar c = 0; c < 3; c++) begin : g_col
			logic signed [63:0] pprod, nprod;
			assign pprod = m_s2[r*3+c] * pos_s2[r];
			assign nprod = m_s2[r*3+c] * nrm_s2[r];
			always_ff @(posedge clk) begin
				if (adv) begin
					pp_s3[0][r][c] <= pprod[63:16];
					pp_s3[1][r][c] <= nprod[63:16];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s2 <= w_s1;
			w_s3 <= w_s2;
			w_s4 <= w_s3;
			for (int c = 0; c < 3; c++) begin
				tr_s3[c] <= m_s2[9+c];
			end
		end
	end

	// skip zero-weight lanes; their matrix may never have been written
	for (genvar c = 0; c < 3; c++) begin : g_sum
		logic signed [49:0] ps, ns;
		assign ps = 50'(tr_s3[c]) + 50'(pp_s3[0][0][c]) + 50'(pp_s3[0][1][c])
			+ 50'(pp_s3[0][2][c]);
		assign ns = 50'(pp_s3[1][0][c]) + 50'(pp_s3[1][1][c]) + 50'(pp_s3[1][2][c]);
		always_ff @(posedge clk) begin
			if (adv) begin
				sum_s4[0][c] <= (w_s3 == 8'd0) ? '0 : ps;
				sum_s4[1][c] <= (w_s3 == 8'd0) ? '0 : ns;
				wsum_s5[c]   <= WSUM_W'(sum_s4[0][c]) * WSUM_W'($signed({1'b0, w_s4}));
				wsum_s5[3+c] <= WSUM_W'(sum_s4[1][c]) * WSUM_W'($signed({1'b0, w_s4}));
			end
		end
	end

endmodule

// ===== rtl/lbvs_div255.sv =====
module lbvs_div255
	import lbvs_pkg::*;
(
	input  logic                    clk,
	input  logic                    adv,
	input  logic signed [ACC_W-1:0] acc,
	output logic signed [31:0]      res_s10
);

	localparam logic [ACC_W-1:0] SAT_LIM = ACC_W'(64'd547608330240);

	logic [ACC_W-1:0] t;
	logic             neg_s7, sat_s7, neg_s8, sat_s8, neg_s9, sat_s9;
	logic [39:0]      t_s7, t_s8, q0_s8, q_s9;
	logic [47:0]      ser;
	logic [39:0]      rem;

	// magnitude plus half of 255, in one add
	assign t = acc[ACC_W-1] ? (~acc + ACC_W'(128)) : (acc + ACC_W'(127));

	// t/255 as a series in 1/256; comes out low by at most one
	assign ser = 48'(t_s7) + 48'(t_s7 >> 8) + 48'(t_s7 >> 16) + 48'(t_s7 >> 24)
		+ 48'(t_s7 >> 32);

	assign rem = t_s8 - (q0_s8 << 8) + q0_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s7 <= acc[ACC_W-1];
			sat_s7 <= (t >= SAT_LIM);
			t_s7   <= t[39:0];
			neg_s8 <= neg_s7;
			sat_s8 <= sat_s7;
			t_s8   <= t_s7;
			q0_s8  <= 40'(ser >> 8);
			neg_s9 <= neg_s8;
			sat_s9 <= sat_s8;
			q_s9   <= q0_s8 + 40'(rem >= 40'd255);
			if (sat_s9) begin
				res_s10 <= neg_s9 ? 32'sh80000000 : 32'sh7FFFFFFF;
			end else begin
				res_s10 <= neg_s9 ? -$signed(q_s9[31:0]) : $signed(q_s9[31:0]);
			end
		end
	end

endmodule

// ===== bench/lbvs_checker.sv =====
`timescale 1ns / 100ps

module lbvs_checker
	import lbvs_pkg::*;
#(
	parameter int unsigned MATRIX_COUNT = 256,
	parameter int unsigned REMAP_DEPTH  = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic               cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] nrm_x,
	input  logic signed [31:0] nrm_y,
	input  logic signed [31:0] nrm_z,
	input  logic [31:0]        bone_indices,
	input  logic [31:0]        bone_weights,
	input  logic [63:0]        uv_bits,
	input  logic [63:0]        table_write,
	input  logic               last_vertex,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] out_pos_x,
	input  logic signed [31:0] out_pos_y,
	input  logic signed [31:0] out_pos_z,
	input  logic signed [31:0] out_nrm_x,
	input  logic signed [31:0] out_nrm_y,
	input  logic signed [31:0] out_nrm_z,
	input  logic [63:0]        out_uv_bits,
	input  logic               out_last,
	output int                 errors,
	output int                 pending,
	output int                 checked
);

	localparam int unsigned MAT_WORDS = MATRIX_COUNT * 16;

	typedef struct packed {
		logic [31:0] px, py, pz, nx, ny, nz;
		logic [63:0] uv;
		logic        last;
	} skinned_t;

	logic [31:0] mat_mem [MAT_WORDS];
	logic [7:0]  remap_mem [REMAP_DEPTH];
	logic        remap_on;
	skinned_t    skinned_q [$];

	initial begin
		errors = 0;
		pending = 0;
		checked = 0;
		remap_on = 1'b0;
		foreach (mat_mem[i]) mat_mem[i] = '0;
		foreach (remap_mem[i]) remap_mem[i] = '0;
	end

	function automatic longint mat_word(int unsigned m, int unsigned r, int unsigned c);
		return longint'($signed(mat_mem[(m * 16 + r * 4 + c) % MAT_WORDS]));
	endfunction

	// round the 255-scaled sum to nearest, then clamp to 32 bits
	function automatic logic [31:0] round_sat(longint acc);
		longint mag, d, q;
		mag = (acc < 0) ? -acc : acc;
		d = (mag + 127) / 255;
		if (d > 64'sh80000000)
			d = 64'sh80000000;
		q = (acc < 0) ? -d : d;
		if (q > 64'sh7fffffff)
			q = 64'sh7fffffff;
		return q[31:0];
	endfunction

	function automatic skinned_t blend_vertex();
		longint pv[3], nv[3], pacc[3], nacc[3];
		longint ps, ns, mv, w;
		int unsigned b, m;
		skinned_t r;
		pv[0] = longint'(pos_x);
		pv[1] = longint'(pos_y);
		pv[2] = longint'(pos_z);
		nv[0] = longint'(nrm_x);
		nv[1] = longint'(nrm_y);
		nv[2] = longint'(nrm_z);
		for (int c = 0; c < 3; c++) begin
			pacc[c] = 0;
			nacc[c] = 0;
		end
		for (int i = 0; i < 4; i++) begin
			w = longint'(bone_weights[8*i +: 8]);
			if (w == 0)
				continue;
			b = 32'(bone_indices[8*i +: 8]);
			if (remap_on)
				b = 32'(remap_mem[b % REMAP_DEPTH]);
			m = b % MATRIX_COUNT;
			for (int c = 0; c < 3; c++) begin
				ps = mat_word(m, 3, c);
				ns = 0;
				for (int k = 0; k < 3; k++) begin
					mv = mat_word(m, k, c);
					ps += (mv * pv[k]) >>> 16;
					ns += (mv * nv[k]) >>> 16;
				end
				pacc[c] += ps * w;
				nacc[c] += ns * w;
			end
		end
		r.px = round_sat(pacc[0]);
		r.py = round_sat(pacc[1]);
		r.pz = round_sat(pacc[2]);
		r.nx = round_sat(nacc[0]);
		r.ny = round_sat(nacc[1]);
		r.nz = round_sat(nacc[2]);
		r.uv = uv_bits;
		r.last = last_vertex;
		return r;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		if (errors < 40)
			$display("%0t: mismatch %s: got %h, want %h", $time, what, got, want);
		errors++;
	endtask

	task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report(what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		skinned_t want;
		if (!arst_n) begin
			remap_on = 1'b0;
			skinned_q.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				remap_on = cfg_data;
			if (in_valid && in_ready) begin
				case (req_e'(req_type))
				REQ_MATRIX: begin
					if (table_write[63:32] < MAT_WORDS)
						mat_mem[table_write[63:32]] = table_write[31:0];
				end
				REQ_REMAP: begin
					if (table_write[63:32] < REMAP_DEPTH)
						remap_mem[table_write[63:32]] = table_write[7:0];
				end
				REQ_SKIN: skinned_q.push_back(blend_vertex());
				default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (skinned_q.size() == 0) begin
					report("result with nothing expected", $unsigned(out_pos_x), '0);
				end else begin
					want = skinned_q.pop_front();
					check_field("out_pos_x", $unsigned(out_pos_x), want.px);
					check_field("out_pos_y", $unsigned(out_pos_y), want.py);
					check_field("out_pos_z", $unsigned(out_pos_z), want.pz);
					check_field("out_nrm_x", $unsigned(out_nrm_x), want.nx);
					check_field("out_nrm_y", $unsigned(out_nrm_y), want.ny);
					check_field("out_nrm_z", $unsigned(out_nrm_z), want.nz);
					check_field("out_uv_bits", out_uv_bits, want.uv);
					check_field("out_last", out_last, want.last);
					checked++;
				end
			end
			pending = skinned_q.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import lbvs_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 800000;
	localparam int unsigned PHASE_ITEMS  = 465;
	localparam int unsigned SETTLE       = 14;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] px, py, pz, nx, ny, nz;
		logic [31:0] idx, wt;
		logic [63:0] uv, tw;
		logic        last;
	} vtx_req_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid, cfg_ready, cfg_data;
	logic               in_valid, in_ready;
	logic [1:0]         req_type;
	logic signed [31:0] pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z;
	logic [31:0]        bone_indices, bone_weights;
	logic [63:0]        uv_bits, table_write;
	logic               last_vertex;
	logic               out_valid, out_ready;
	logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
	logic signed [31:0] out_nrm_x, out_nrm_y, out_nrm_z;
	logic [63:0]        out_uv_bits;
	logic               out_last;

	int errors, pending, checked;
	int cycles;
	int sent;
	int hold_left;   // long receiver hold-off, counted down by the receiver
	bit calm;        // stretch with no idling on either side
	bit remap_mode;  // mirror of use_remap for index selection

	// which matrices and remap entries are safe to read
	logic [15:0] words_seen [256];
	bit          mat_ok [256];
	bit          remap_ok [256];
	logic [7:0]  ok_mats [$];
	logic [7:0]  ok_remaps [$];

	linear_blend_vertex_skinning u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.nrm_x(nrm_x), .nrm_y(nrm_y), .nrm_z(nrm_z),
		.bone_indices(bone_indices), .bone_weights(bone_weights),
		.uv_bits(uv_bits), .table_write(table_write), .last_vertex(last_vertex),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
		.out_nrm_x(out_nrm_x), .out_nrm_y(out_nrm_y), .out_nrm_z(out_nrm_z),
		.out_uv_bits(out_uv_bits), .out_last(out_last)
	);

	lbvs_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.nrm_x(nrm_x), .nrm_y(nrm_y), .nrm_z(nrm_z),
		.bone_indices(bone_indices), .bone_weights(bone_weights),
		.uv_bits(uv_bits), .table_write(table_write), .last_vertex(last_vertex),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
		.out_nrm_x(out_nrm_x), .out_nrm_y(out_nrm_y), .out_nrm_z(out_nrm_z),
		.out_uv_bits(out_uv_bits), .out_last(out_last),
		.errors(errors), .pending(pending), .checked(checked)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Idle length: mostly none or short, now and then a long one.
	function automatic int gap_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(50, 20);
	endfunction

	// Q16.16 value: extremes, small magnitudes, or any 32-bit pattern.
	function automatic logic [31:0] q16_val(bit tame);
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return 32'h8000_0000;
		if (r == 1)
			return 32'h7fff_ffff;
		if (r < 7 || tame)
			return $urandom_range(32'h0008_0000) - 32'h0004_0000;
		return $urandom;
	endfunction

	// Receiver: drop ready for random stalls, and for the long hold-off.
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else begin
				out_ready = 1'b1;
				if (!calm && $urandom_range(3) == 0)
					stall_left = gap_len();
			end
		end
	end

	// Offer one item after an optional gap and hold it until its transfer.
	task automatic offer(vtx_req_t it);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		req_type = it.kind;
		pos_x = it.px;
		pos_y = it.py;
		pos_z = it.pz;
		nrm_x = it.nx;
		nrm_y = it.ny;
		nrm_z = it.nz;
		bone_indices = it.idx;
		bone_weights = it.wt;
		uv_bits = it.uv;
		table_write = it.tw;
		last_vertex = it.last;
		do @(posedge clk); while (!in_ready);
		sent++;
		calm = ((sent / 90) % 4) == 3;
	endtask

	// Load item; the non-table fields carry noise, which the block ignores.
	task automatic load(req_e kind, logic [31:0] addr, logic [31:0] data);
		vtx_req_t it;
		it = '{kind: kind, px: $urandom, py: $urandom, pz: $urandom,
			nx: $urandom, ny: $urandom, nz: $urandom, idx: $urandom,
			wt: $urandom, uv: {$urandom, $urandom}, tw: {addr, data},
			last: 1'($urandom_range(1))};
		offer(it);
		if (kind == REQ_MATRIX && addr < 4096) begin
			words_seen[addr / 16][addr % 16] = 1'b1;
			if (&words_seen[addr / 16] && !mat_ok[addr / 16]) begin
				mat_ok[addr / 16] = 1'b1;
				ok_mats.push_back(8'(addr / 16));
			end
		end
		if (kind == REQ_REMAP && addr < 256 && !remap_ok[addr]) begin
			remap_ok[addr] = 1'b1;
			ok_remaps.push_back(8'(addr));
		end
	endtask

	task automatic skin(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
		logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
		logic [31:0] idx, logic [31:0] wt, logic [63:0] uv, logic last);
		vtx_req_t it;
		it = '{kind: REQ_SKIN, px: px, py: py, pz: pz, nx: nx, ny: ny, nz: nz,
			idx: idx, wt: wt, uv: uv, tw: {$urandom, $urandom}, last: last};
		offer(it);
	endtask

	// Random vertex: live lanes only point at fully loaded matrices.
	task automatic random_skin();
		logic [31:0] idx, wt;
		logic [7:0]  w;
		bit          tame;
		tame = $urandom_range(3) != 0;
		for (int i = 0; i < 4; i++) begin
			case ($urandom_range(9))
			0, 1, 2: w = 8'd0;
			3:       w = 8'd255;
			default: w = 8'($urandom_range(255, 1));
			endcase
			wt[8*i +: 8] = w;
			if (w == 0)
				idx[8*i +: 8] = 8'($urandom);
			else if (remap_mode)
				idx[8*i +: 8] = ok_remaps[$urandom_range(ok_remaps.size() - 1)];
			else
				idx[8*i +: 8] = ok_mats[$urandom_range(ok_mats.size() - 1)];
		end
		skin(q16_val(tame), q16_val(tame), q16_val(tame), q16_val(tame),
			q16_val(tame), q16_val(tame), idx, wt, {$urandom, $urandom},
			1'($urandom_range(1)));
	endtask

	task automatic load_matrix(int m, bit tame);
		for (int w = 0; w < 16; w++)
			load(REQ_MATRIX, m * 16 + w, q16_val(tame));
	endtask

	// Write use_remap only once the pipe has drained.
	task automatic write_cfg(bit v);
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		remap_mode = v;
	endtask

	initial begin
		int r;
		bit held;
		cycles = 0;
		sent = 0;
		hold_left = 0;
		held = 1'b0;
		calm = 1'b0;
		remap_mode = 1'b0;
		foreach (words_seen[i]) words_seen[i] = '0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_NONE;
		{pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z} = '0;
		{bone_indices, bone_weights, uv_bits, table_write, last_vertex} = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_cfg(1'b0);

		// Matrix 0: identity scaled by one with a translation row.
		for (int w = 0; w < 16; w++)
			load(REQ_MATRIX, w, (w < 12 && w % 5 == 0) ? 32'h0001_0000 :
				(w >= 12 ? 32'h0002_8000 + w : 32'h0));
		// Matrix 255: full-scale entries to drive the sums into saturation.
		for (int w = 0; w < 16; w++)
			load(REQ_MATRIX, 255 * 16 + w, w[0] ? 32'h8000_0000 : 32'h7fff_ffff);

		// Directed vertices.
		skin('0, '0, '0, '0, '0, '0, 32'hffff_ffff, 32'h0, 64'h0, 1'b0);
		skin(32'h0001_0000, 32'hfffe_0000, 32'h0000_8000, 32'h0001_0000, '0, '0,
			32'h0, 32'h0000_00ff, 64'hffff_ffff_ffff_ffff, 1'b1);
		skin(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff, 64'h0, 1'b0);
		skin(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'hff00_ff00, 32'hff01_0180,
			64'hdead_beef_0123_4567, 1'b1);
		skin(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff, 32'h8000_0000,
			32'hffff_ffff, 32'h00ff_00ff, 32'h0102_0304, 64'h1, 1'b0);
		skin(32'hffff_ffff, 32'h0000_0001, 32'h0, 32'hffff_ffff, 32'h1, 32'h0,
			32'h0000_0000, 32'h0000_0001, 64'h8000_0000_0000_0000, 1'b1);

		// Loads that must be ignored, and the unused request code.
		load(REQ_MATRIX, 32'd4096, 32'h1234_5678);
		load(REQ_MATRIX, 32'hffff_ffff, 32'hffff_ffff);
		load(REQ_REMAP, 32'd256, 32'h0000_00ff);
		load(REQ_REMAP, 32'hffff_ffff, 32'hffff_ffff);
		load(REQ_NONE, $urandom, $urandom);

		// Remap: entry 0 to matrix 255, entry 255 to matrix 0; upper data dropped.
		load(REQ_REMAP, 32'd0, 32'hffff_ffff);
		load(REQ_REMAP, 32'd255, 32'hffff_ff00);
		write_cfg(1'b1);
		skin(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0001_0000,
			32'h0, 32'h0000_ff00, 32'h0000_ff00, 64'h0, 1'b1);
		skin(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h1, 32'h1, 32'h1,
			32'hff00_00ff, 32'h8040_2010, 64'h5555_aaaa_5555_aaaa, 1'b0);

		// Random phases, alternating remap on and off.
		for (int ph = 0; ph < 4; ph++) begin
			write_cfg(ph[0]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// one long hold-off so the pipe fills and stalls its input
				if (ph == 1 && n >= 150 && !held) begin
					hold_left = 400;
					held = 1'b1;
				end
				r = $urandom_range(99);
				if (r < 3) begin
					load_matrix($urandom_range(255), 1'($urandom_range(1)));
					n += 15;
				end else if (r < 9) begin
					load(REQ_REMAP, $urandom_range(255),
						{24'($urandom_range(16777215)),
						ok_mats[$urandom_range(ok_mats.size() - 1)]});
				end else if (r < 12) begin
					load(r == 9 ? REQ_NONE : (r == 10 ? REQ_MATRIX : REQ_REMAP),
						$urandom_range(32'hffff_ffff, 32'h1000), $urandom);
				end else begin
					random_skin();
				end
			end
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Sent %0d input transfers; %0d skinned vertices checked.", sent, checked);
		$display("Covered %0d loaded matrices, %0d remap entries, remap on and off.",
			ok_mats.size(), ok_remaps.size());
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
